// ===== sv/vinit_pkg.sv =====
package vinit_pkg;

  localparam int PosW         = 10;
  localparam int ValW         = 32;
  localparam int StatW        = 3;
  localparam int SizeW        = 11;
  localparam int DepthDefault = 1024;
  localparam logic [SizeW-1:0] SizeReset = 11'd1024;

  typedef enum logic [1:0] {
    MODE_QUERY  = 2'd0,
    MODE_ASSIGN = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [StatW-1:0] {
    STATUS_ASSIGNED = 3'd0,
    STATUS_FOUND    = 3'd1,
    STATUS_NOT_INIT = 3'd2,
    STATUS_INVALID  = 3'd3,
    STATUS_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_QUERY,
    CMD_ASSIGN,
    CMD_CLEAR,
    CMD_INVALID
  } cmd_e;

  typedef struct packed {
    cmd_e                   kind;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_CHECK
  } back_state_e;

endpackage

// ===== sv/vinit_ram.sv =====
module vinit_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  // two-state storage: an entry never written reads as a defined value
  bit   [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/vinit_front.sv =====
module vinit_front import vinit_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cfg_we_i,
  input  logic [SizeW-1:0]       cfg_wdata_i,
  input  logic [1:0]             mode_i,
  input  logic [PosW-1:0]        position_i,
  input  logic signed [ValW-1:0] write_value_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  logic                   cmd_pop_i
);

  logic [SizeW-1:0] size_q;
  cmd_t             fifo_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pos_ok;
  cmd_t             cmd_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // a size above the table depth saturates to the depth
  assign pos_ok = (SizeW'(position_i) < size_q) && (32'(position_i) < DEPTH);

  always_comb begin
    cmd_new.pos   = position_i;
    cmd_new.value = write_value_i;
    unique case (mode_i)
      MODE_QUERY:  cmd_new.kind = pos_ok ? CMD_QUERY : CMD_INVALID;
      MODE_ASSIGN: cmd_new.kind = pos_ok ? CMD_ASSIGN : CMD_INVALID;
      MODE_CLEAR:  cmd_new.kind = CMD_CLEAR;
      default:     cmd_new.kind = CMD_INVALID;
    endcase
  end

  assign busy        = (cnt_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

// ===== sv/vinit_back.sv =====
module vinit_back import vinit_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   cmd_pop_o,
  output logic                   done_o,
  output logic [StatW-1:0]       status_o,
  output logic signed [ValW-1:0] read_value_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = $clog2(DEPTH + 1);

  back_state_e state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [RW-1:0] count_q, count_d;
  logic        rank_ok_q, rank_ok_d;
  logic        done_q, done_d;
  status_e     status_q, status_d;
  logic signed [ValW-1:0] rdata_q, rdata_d;

  logic          rank_re, rank_we;
  logic [AW-1:0] rank_raddr, rank_waddr;
  logic [RW-1:0] rank_wdata, rank_rdata;
  logic          order_re, order_we;
  logic [AW-1:0] order_raddr, order_waddr;
  logic [PosW-1:0] order_wdata, order_rdata;
  logic          val_re, val_we;
  logic [AW-1:0] val_raddr, val_waddr;
  logic [ValW-1:0] val_wdata, val_rdata;
  logic          hit;

  vinit_ram #(.Width(RW), .Depth(DEPTH)) u_rank_ram (
    .clk_i, .we_i(rank_we), .waddr_i(rank_waddr), .wdata_i(rank_wdata),
    .re_i(rank_re), .raddr_i(rank_raddr), .rdata_o(rank_rdata)
  );

  vinit_ram #(.Width(PosW), .Depth(DEPTH)) u_order_ram (
    .clk_i, .we_i(order_we), .waddr_i(order_waddr), .wdata_i(order_wdata),
    .re_i(order_re), .raddr_i(order_raddr), .rdata_o(order_rdata)
  );

  vinit_ram #(.Width(ValW), .Depth(DEPTH)) u_value_ram (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_wdata),
    .re_i(val_re), .raddr_i(val_raddr), .rdata_o(val_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == CMD_QUERY || cmd_i.kind == CMD_ASSIGN)) begin
          state_d = ST_RANK;
        end
      end
      ST_RANK:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // the position is live only if its rank points back at it from the order store
  assign hit = rank_ok_q && (order_rdata == cur_q.pos);

  // outputs and datapath
  always_comb begin
    cmd_pop_o   = 1'b0;
    cur_d       = cur_q;
    count_d     = count_q;
    rank_ok_d   = rank_ok_q;
    done_d      = 1'b0;
    status_d    = status_q;
    rdata_d     = '0;
    rank_re     = 1'b0;
    rank_raddr  = AW'(cmd_i.pos);
    rank_we     = 1'b0;
    rank_waddr  = AW'(cur_q.pos);
    rank_wdata  = count_q + 1'b1;
    order_re    = 1'b0;
    order_raddr = AW'(rank_rdata - 1'b1);
    order_we    = 1'b0;
    order_waddr = AW'(count_q);
    order_wdata = cur_q.pos;
    val_re      = 1'b0;
    val_raddr   = AW'(cur_q.pos);
    val_we      = 1'b0;
    val_waddr   = AW'(cur_q.pos);
    val_wdata   = cur_q.value;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          case (cmd_i.kind)
            CMD_CLEAR: begin
              count_d  = '0;
              done_d   = 1'b1;
              status_d = STATUS_CLEARED;
            end
            CMD_INVALID: begin
              done_d   = 1'b1;
              status_d = STATUS_INVALID;
            end
            default: begin
              rank_re = 1'b1;
            end
          endcase
        end
      end
      ST_RANK: begin
        order_re  = 1'b1;
        val_re    = 1'b1;
        rank_ok_d = (rank_rdata != '0) && (rank_rdata <= count_q);
      end
      ST_CHECK: begin
        done_d = 1'b1;
        if (cur_q.kind == CMD_ASSIGN) begin
          status_d = STATUS_ASSIGNED;
          val_we   = 1'b1;
          // append on first write; a full order keeps its count
          if (!hit && (count_q < RW'(DEPTH))) begin
            order_we = 1'b1;
            rank_we  = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end else if (hit) begin
          status_d = STATUS_FOUND;
          rdata_d  = val_rdata;
        end else begin
          status_d = STATUS_NOT_INIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rank_ok_q <= rank_ok_d;
    status_q  <= status_d;
    rdata_q   <= rdata_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rdata_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= RW'(DEPTH))
    else $error("init count above depth");

  a_rank_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RANK |=> state_q == ST_CHECK)
    else $error("rank lookup not followed by check");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STATUS_FOUND) |-> rdata_q == '0)
    else $error("read value nonzero without a hit");

  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cmd_valid_i && cmd_i.kind == CMD_CLEAR) |=> count_q == '0)
    else $error("clear left count nonzero");

endmodule

// ===== sv/virtual_init_array_core.sv =====
// Table with constant-time clear: a value, a rank and an order store that are
// never swept, plus a count of positions written since the last clear.
//
// Command channel: drive mode_i, position_i, write_value_i with start high; the
// transaction is taken at a rising edge where busy is low. Commands are
// classified on entry and held in a two-entry queue ahead of the execution
// engine, so busy rises only when that queue is full.
// Result channel: done_o is high for one cycle with status_o and read_value_o;
// the receiver cannot stall it and must take the result in that cycle.
// Configuration: cfg_we_i writes cfg_wdata_i into the size register (default
// 1024); write it only while no command is outstanding.
// Sequencing: a query or assign reads the rank, then the order and value stores
// (two dependent registered RAM reads), and is then checked and written back;
// the engine takes no new command until it is back in idle. A clear or a
// rejected command is completed in the idle state.
// Reset: the count clears and the size returns to 1024 at once; the RAMs are
// left as they are, since a stale rank never passes the back-pointer check.
module virtual_init_array_core import vinit_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cfg_we_i,
  input  logic [SizeW-1:0]       cfg_wdata_i,
  input  logic [1:0]             mode_i,
  input  logic [PosW-1:0]        position_i,
  input  logic signed [ValW-1:0] write_value_i,
  output logic                   done_o,
  output logic [StatW-1:0]       status_o,
  output logic signed [ValW-1:0] read_value_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  vinit_front #(.DEPTH(DEPTH)) u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cfg_we_i,
    .cfg_wdata_i,
    .mode_i,
    .position_i,
    .write_value_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  vinit_back #(.DEPTH(DEPTH)) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .done_o,
    .status_o,
    .read_value_o
  );

endmodule

// ===== verif/virtual_init_array_core_test.sv =====
`timescale 1ns / 1ps

module virtual_init_array_core_test;
  import vinit_pkg::*;

  localparam int Depth = DepthDefault;
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int StallLimit = 2000;
  localparam int FlushCycles = 8;

  typedef struct {
    status_e                status;
    logic signed [ValW-1:0] value;
  } response_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   cfg_we_i = 1'b0;
  logic [SizeW-1:0]       cfg_wdata_i = '0;
  logic [1:0]             mode_i = '0;
  logic [PosW-1:0]        position_i = '0;
  logic signed [ValW-1:0] write_value_i = '0;
  logic                   done_o;
  logic [StatW-1:0]       status_o;
  logic signed [ValW-1:0] read_value_o;

  // Shadow copy of the table
  logic signed [ValW-1:0] stored_value [Depth];
  logic [SizeW-1:0]       pos_rank [Depth];
  logic [PosW-1:0]        rank_pos [Depth];
  logic [SizeW-1:0]       live_count;
  logic [SizeW-1:0]       table_size;

  response_t awaited[$];
  int error_count = 0;
  int sent_count = 0;
  int status_seen [5];
  int stall_cycles = 0;
  int burst_left = 0;
  bit quiet_phase = 1'b0;

  virtual_init_array_core #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .write_value_i(write_value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit is_live(input logic [PosW-1:0] pos);
    logic [SizeW-1:0] r;
    r = pos_rank[pos];
    if (r == 0 || r > live_count || r > Depth) return 1'b0;
    return rank_pos[r - 1] == pos;
  endfunction

  // Apply one command to the shadow table and return the response it produces.
  function automatic response_t table_response(input logic [1:0] mode,
                                               input logic [PosW-1:0] pos,
                                               input logic signed [ValW-1:0] value);
    response_t resp;
    logic [SizeW-1:0] span;
    span = (table_size > Depth) ? SizeW'(Depth) : table_size;
    resp.value = '0;
    if (mode == MODE_CLEAR) begin
      live_count = '0;
      resp.status = STATUS_CLEARED;
    end else if (mode == ModeUnused || pos >= span) begin
      resp.status = STATUS_INVALID;
    end else if (mode == MODE_ASSIGN) begin
      // Append on first write since the last clear, unless the order is full
      if (!is_live(pos) && live_count < Depth) begin
        live_count = live_count + 1'b1;
        rank_pos[live_count - 1] = pos;
        pos_rank[pos] = live_count;
      end
      stored_value[pos] = value;
      resp.status = STATUS_ASSIGNED;
    end else if (is_live(pos)) begin
      resp.status = STATUS_FOUND;
      resp.value = stored_value[pos];
    end else begin
      resp.status = STATUS_NOT_INIT;
    end
    return resp;
  endfunction

  // Caller stands at a rising edge; returns at the edge that took the transaction.
  task automatic issue_command(input logic [1:0] mode, input logic [PosW-1:0] pos,
                               input logic signed [ValW-1:0] value);
    mode_i <= mode;
    position_i <= pos;
    write_value_i <= value;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    awaited.push_back(table_response(mode, pos, value));
    sent_count++;
  endtask

  task automatic pace_sender();
    if (quiet_phase) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
    burst_left = $urandom_range(0, 12);
  endtask

  task automatic send_paced(input logic [1:0] mode, input logic [PosW-1:0] pos,
                            input logic signed [ValW-1:0] value);
    issue_command(mode, pos, value);
    pace_sender();
  endtask

  // Drain outstanding transactions, then write the size register.
  task automatic write_table_size(input logic [SizeW-1:0] size);
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_size = size;
  endtask

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return -1;
      2: return 32'sh8000_0000;
      3: return 32'sh7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_state();
    send_paced(MODE_QUERY, 10'd0, 0);
    send_paced(MODE_QUERY, 10'd1023, 0);
    send_paced(MODE_ASSIGN, 10'd1023, 32'sh7FFF_FFFF);
    send_paced(MODE_QUERY, 10'd1023, 0);
    send_paced(MODE_ASSIGN, 10'd0, 32'sh8000_0000);
    send_paced(MODE_QUERY, 10'd0, 0);
    // Overwrite keeps the rank, count stays at two
    send_paced(MODE_ASSIGN, 10'd0, -1);
    send_paced(MODE_QUERY, 10'd0, -1);
    send_paced(MODE_QUERY, 10'd512, 0);
    send_paced(ModeUnused, 10'd5, 32'sh1234_5678);
    send_paced(MODE_CLEAR, 10'h3FF, -1);
    send_paced(MODE_QUERY, 10'd0, 0);
    send_paced(MODE_QUERY, 10'd1023, 0);
    // Stale rank of 1023 must be re-appended
    send_paced(MODE_ASSIGN, 10'd1023, 0);
    send_paced(MODE_QUERY, 10'd1023, 0);
    send_paced(MODE_QUERY, 10'd0, 0);
  endtask

  task automatic test_size_limits();
    write_table_size(11'd0);
    send_paced(MODE_QUERY, 10'd0, 0);
    send_paced(MODE_ASSIGN, 10'd0, 32'sh55AA_55AA);
    send_paced(MODE_CLEAR, 10'd0, 0);
    write_table_size(11'd1);
    send_paced(MODE_ASSIGN, 10'd0, 32'shAA55_AA55);
    send_paced(MODE_QUERY, 10'd0, 0);
    send_paced(MODE_QUERY, 10'd1, 0);
    send_paced(MODE_ASSIGN, 10'd1, 7);
    write_table_size(11'd2047);
    send_paced(MODE_QUERY, 10'd1023, 0);
    send_paced(MODE_ASSIGN, 10'd1023, 32'sh0F0F_F0F0);
    send_paced(MODE_QUERY, 10'd1023, 0);
    write_table_size(SizeReset);
  endtask

  // Fill every position in random order to drive the count to its maximum.
  task automatic test_table_fill();
    int order [Depth];
    int j;
    int tmp;
    for (int i = 0; i < Depth; i++) order[i] = i;
    for (int i = Depth - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    quiet_phase = 1'b0;
    send_paced(MODE_CLEAR, PosW'($urandom), $urandom);
    for (int i = 0; i < Depth; i++) begin
      send_paced(MODE_ASSIGN, PosW'(order[i]), pick_value());
      if ($urandom_range(0, 9) == 0) send_paced(MODE_QUERY, PosW'($urandom), 0);
    end
    // Table full: overwrites must not append
    repeat (20) begin
      send_paced(MODE_ASSIGN, PosW'($urandom), pick_value());
      send_paced(MODE_QUERY, PosW'($urandom), 0);
    end
    send_paced(MODE_CLEAR, 10'd0, 0);
    repeat (10) send_paced(MODE_QUERY, PosW'($urandom), 0);
  endtask

  task automatic test_random_mix();
    logic [SizeW-1:0] sizes [8];
    logic [SizeW-1:0] span;
    int win_base;
    int roll;
    logic [PosW-1:0] pos;
    sizes = '{11'd1, 11'd2047, 11'(($urandom_range(1, 64))), 11'd1024, 11'd0,
              11'(($urandom_range(1, 2047))), 11'd1024, 11'(($urandom_range(1, 40)))};
    for (int ph = 0; ph < 8; ph++) begin
      write_table_size(sizes[ph]);
      quiet_phase = (ph % 3 == 1);
      span = (sizes[ph] > Depth) ? SizeW'(Depth) : sizes[ph];
      win_base = (span <= 16) ? 0 : $urandom_range(0, span - 16);
      repeat ((sizes[ph] == 0) ? 20 : 80) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) pos = PosW'($urandom);
        else pos = PosW'(win_base + $urandom_range(0, 17));
        if (roll < 3) send_paced(MODE_CLEAR, pos, $urandom);
        else if (roll < 5) send_paced(ModeUnused, pos, $urandom);
        else if (roll < 50) send_paced(MODE_ASSIGN, pos, pick_value());
        else send_paced(MODE_QUERY, pos, $urandom);
      end
    end
  endtask

  always @(posedge clk_i) begin
    response_t head;
    if (rst_ni && done_o) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status %0d value %0d", $time, status_o,
                 read_value_o);
        error_count++;
      end else begin
        head = awaited.pop_front();
        if (status_o < 5) status_seen[status_o]++;
        if (status_o !== head.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, head.status,
                   status_o);
          error_count++;
        end
        if (read_value_o !== head.value) begin
          $display("%0t: read_value mismatch, expected %0d actual %0d", $time,
                   head.value, read_value_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < Depth; i++) begin
      stored_value[i] = '0;
      pos_rank[i] = '0;
      rank_pos[i] = '0;
    end
    live_count = '0;
    table_size = SizeReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_size_limits();
    test_table_fill();
    test_random_mix();
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (FlushCycles) @(posedge clk_i);
    $display("Sent %0d commands: %0d assigned, %0d found, %0d not initialized,",
             sent_count, status_seen[STATUS_ASSIGNED], status_seen[STATUS_FOUND],
             status_seen[STATUS_NOT_INIT]);
    $display("  %0d invalid, %0d cleared; sizes 0, 1, 1024, 2047 and random, full table",
             status_seen[STATUS_INVALID], status_seen[STATUS_CLEARED]);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== virtual_init_array_core.f =====
sv/vinit_pkg.sv
sv/vinit_ram.sv
sv/vinit_front.sv
sv/vinit_back.sv
sv/virtual_init_array_core.sv
verif/virtual_init_array_core_test.sv
